// File: sv/hlos_pkg.sv
// shared types and constants for the heightfield line-of-sight core
// no dependencies
package hlos_pkg;

   localparam int GRID_DIM    = 64;
   localparam int COORD_BITS  = 6;
   localparam int ADDR_BITS   = 2 * COORD_BITS;
   localparam int HEIGHT_BITS = 8;

   localparam logic [1:0] CMD_WRITE_MIN = 2'd0;
   localparam logic [1:0] CMD_WRITE_MAX = 2'd1;
   localparam logic [1:0] CMD_QUERY     = 2'd2;

   localparam logic [1:0] REG_GRID_WIDTH    = 2'd0;
   localparam logic [1:0] REG_GRID_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_LEVEL_COUNT   = 2'd2;
   localparam logic [1:0] REG_LEVEL_SPACING = 2'd3;

   typedef enum logic [1:0] {
      KIND_WRITE_MIN,
      KIND_WRITE_MAX,
      KIND_VISIBLE,
      KIND_MARCH
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [COORD_BITS-1:0]   cell_x;
      logic [COORD_BITS-1:0]   cell_y;
      logic [HEIGHT_BITS-1:0]  height_value;
      logic [7:0]              src_level;
      logic [COORD_BITS-1:0]   dst_x;
      logic [COORD_BITS-1:0]   dst_y;
   } op_type;

   typedef struct packed {
      logic [6:0] grid_width;
      logic [6:0] grid_height;
      logic [7:0] level_count;
      logic [7:0] level_spacing;
   } cfg_type;

endpackage

// File: sv/hlos_front.sv
// front end: classifies incoming words into map writes, trivial answers and marches
// depends on hlos_pkg
module hlos_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_command,
   input  logic [5:0]       req_cell_x,
   input  logic [5:0]       req_cell_y,
   input  logic [7:0]       req_height_value,
   input  logic [7:0]       req_src_level,
   input  logic [5:0]       req_dst_x,
   input  logic [5:0]       req_dst_y,
   input  hlos_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             push,
   output hlos_pkg::op_type push_op
);

   logic [6:0] gw;
   logic [6:0] gh;
   logic       outside;
   logic       useful;

   assign gw = (cfg.grid_width > 7'(hlos_pkg::GRID_DIM)) ? 7'(hlos_pkg::GRID_DIM)
                                                          : cfg.grid_width;
   assign gh = (cfg.grid_height > 7'(hlos_pkg::GRID_DIM)) ? 7'(hlos_pkg::GRID_DIM)
                                                           : cfg.grid_height;

   assign outside = ({1'b0, req_cell_x} >= gw) || ({1'b0, req_cell_y} >= gh) ||
                    ({1'b0, req_dst_x} >= gw) || ({1'b0, req_dst_y} >= gh) ||
                    (req_src_level >= cfg.level_count);

   always_comb begin
      push_op.cell_x       = req_cell_x;
      push_op.cell_y       = req_cell_y;
      push_op.height_value = req_height_value;
      push_op.src_level    = req_src_level;
      push_op.dst_x        = req_dst_x;
      push_op.dst_y        = req_dst_y;
      useful               = 1'b1;
      case (req_command)
         hlos_pkg::CMD_WRITE_MIN: push_op.kind = hlos_pkg::KIND_WRITE_MIN;
         hlos_pkg::CMD_WRITE_MAX: push_op.kind = hlos_pkg::KIND_WRITE_MAX;
         hlos_pkg::CMD_QUERY:
            push_op.kind = outside ? hlos_pkg::KIND_VISIBLE : hlos_pkg::KIND_MARCH;
         default: begin
            push_op.kind = hlos_pkg::KIND_VISIBLE;
            useful       = 1'b0;
         end
      endcase
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full && useful;

endmodule

// File: sv/hlos_queue.sv
// two-entry queue of classified words between front and back
// depends on hlos_pkg
module hlos_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hlos_pkg::op_type push_op,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output hlos_pkg::op_type head
);

   hlos_pkg::op_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: sv/hlos_back.sv
// back end: height maps, step root search, ray march and result register
// depends on hlos_pkg
module hlos_back (
   input  logic             clock,
   input  logic             reset,
   input  hlos_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  hlos_pkg::op_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_visible
);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_SETUP, S_ROOT, S_SQ_A, S_SQ_B, S_SCALE, S_MARCH
   } state_type;

   localparam logic [17:0] ONE_Q16 = 18'd65536;

   state_type state_ff, state_in;

   logic [7:0]  min_mem [4096];
   logic [7:0]  max_mem [4096];
   logic [7:0]  min_rd_ff;
   logic [7:0]  max_rd_ff;
   logic [11:0] min_ra;
   logic [11:0] max_ra;
   logic        min_we;
   logic        max_we;

   logic [5:0]  sx_ff, sy_ff, tx_ff, ty_ff;
   logic [7:0]  lvl_ff;
   logic [7:0]  hmax_ff;
   logic signed [6:0]  dx_ff, dy_ff;
   logic [15:0] srcz_ff;
   logic [12:0] d2_ff;
   logic signed [17:0] dz_ff;
   logic [16:0] s_ff, s_in;
   logic [4:0]  bit_ff, bit_in;
   logic [33:0] sq_ff;
   logic signed [25:0] dxs_ff, dys_ff;
   logic signed [35:0] dzs_ff;
   logic signed [25:0] xq_ff, yq_ff;
   logic signed [39:0] zq_ff;
   logic [17:0] p_ff;
   logic [16:0] zc_ff;
   logic        chk_ff;
   logic        rsp_valid_ff;
   logic        rsp_visible_ff;
   logic        vis_ff;
   logic        fin_ff;

   logic [7:0]  sp;
   logic [16:0] srcz_mul;
   logic signed [6:0] dx_in, dy_in;
   logic signed [14:0] d2_sum;
   logic [16:0] trial;
   logic [46:0] prod;
   logic signed [25:0] dxs_mul, dys_mul;
   logic signed [35:0] dzs_mul;
   logic        rsp_free;
   logic        blocked;

   assign sp       = (cfg.level_spacing == 8'd0) ? 8'd1 : cfg.level_spacing;
   assign srcz_mul = 17'({1'b0, lvl_ff} + 9'd1) * 17'(sp);
   assign dx_in    = $signed({1'b0, tx_ff}) - $signed({1'b0, sx_ff});
   assign dy_in    = $signed({1'b0, ty_ff}) - $signed({1'b0, sy_ff});
   assign d2_sum   = dx_ff * dx_ff + dy_ff * dy_ff;
   assign trial    = s_ff | (17'd1 << bit_ff);
   assign prod     = sq_ff * d2_ff;
   assign dxs_mul  = dx_ff * $signed({1'b0, s_ff});
   assign dys_mul  = dy_ff * $signed({1'b0, s_ff});
   assign dzs_mul  = dz_ff * $signed({1'b0, s_ff});
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign blocked  = chk_ff && (zc_ff < {9'd0, min_rd_ff});

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   always_comb begin
      pop    = 1'b0;
      min_we = 1'b0;
      max_we = 1'b0;
      min_ra = {yq_ff[21:16], xq_ff[21:16]};
      max_ra = {head.dst_y, head.dst_x};
      if (state_ff == S_IDLE && !q_empty && !fin_ff) begin
         case (head.kind)
            hlos_pkg::KIND_WRITE_MIN: begin
               pop    = 1'b1;
               min_we = 1'b1;
            end
            hlos_pkg::KIND_WRITE_MAX: begin
               pop    = 1'b1;
               max_we = 1'b1;
            end
            hlos_pkg::KIND_VISIBLE: pop = rsp_free;
            hlos_pkg::KIND_MARCH: pop = 1'b1;
            default: pop = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (min_we) begin
         min_mem[{head.cell_y, head.cell_x}] <= head.height_value;
      end
      if (max_we) begin
         max_mem[{head.cell_y, head.cell_x}] <= head.height_value;
      end
      min_rd_ff <= min_mem[min_ra];
      max_rd_ff <= max_mem[max_ra];
   end

   always_comb begin
      state_in = state_ff;
      s_in     = s_ff;
      bit_in   = bit_ff;
      case (state_ff)
         S_IDLE:
            if (pop && head.kind == hlos_pkg::KIND_MARCH) begin
               state_in = S_LOAD;
            end
         S_LOAD:  state_in = S_SETUP;
         S_SETUP: state_in = S_ROOT;
         S_ROOT: begin
            if (d2_ff == 13'd0) begin
               s_in     = 17'd65537;
               state_in = S_SCALE;
            end else begin
               s_in     = 17'd0;
               bit_in   = 5'd16;
               state_in = S_SQ_A;
            end
         end
         S_SQ_A: state_in = S_SQ_B;
         S_SQ_B: begin
            if (prod <= 47'h1_0000_0000) begin
               s_in = trial;
            end
            if (bit_ff == 5'd0) begin
               state_in = S_SCALE;
            end else begin
               bit_in   = bit_ff - 5'd1;
               state_in = S_SQ_A;
            end
         end
         S_SCALE: state_in = S_MARCH;
         S_MARCH:
            if (blocked || (p_ff > ONE_Q16 && !chk_ff)) begin
               state_in = S_IDLE;
            end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         fin_ff         <= 1'b0;
         chk_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fin_ff && rsp_free) begin
            rsp_valid_ff   <= 1'b1;
            rsp_visible_ff <= vis_ff;
            fin_ff         <= 1'b0;
         end else if (pop && head.kind == hlos_pkg::KIND_VISIBLE) begin
            rsp_valid_ff   <= 1'b1;
            rsp_visible_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_SCALE) begin
            chk_ff <= 1'b0;
         end else if (state_ff == S_MARCH) begin
            chk_ff <= (p_ff <= ONE_Q16);
            if (blocked) begin
               vis_ff <= 1'b0;
               fin_ff <= 1'b1;
            end else if (p_ff > ONE_Q16 && !chk_ff) begin
               vis_ff <= 1'b1;
               fin_ff <= 1'b1;
            end
         end
      end
      s_ff   <= s_in;
      bit_ff <= bit_in;
      if (pop) begin
         sx_ff  <= head.cell_x;
         sy_ff  <= head.cell_y;
         tx_ff  <= head.dst_x;
         ty_ff  <= head.dst_y;
         lvl_ff <= head.src_level;
      end
      if (state_ff == S_LOAD) begin
         hmax_ff <= max_rd_ff;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         srcz_ff <= 16'(srcz_mul - 17'd1);
      end
      if (state_ff == S_SETUP) begin
         d2_ff <= d2_sum[12:0];
         dz_ff <= $signed({10'd0, hmax_ff}) - $signed({2'd0, srcz_ff});
      end
      if (state_ff == S_SQ_A) begin
         sq_ff <= trial * trial;
      end
      if (state_ff == S_SCALE) begin
         dxs_ff <= dxs_mul;
         dys_ff <= dys_mul;
         dzs_ff <= dzs_mul;
         xq_ff  <= $signed({4'd0, sx_ff, 16'd0});
         yq_ff  <= $signed({4'd0, sy_ff, 16'd0});
         zq_ff  <= $signed({8'd0, srcz_ff, 16'd0});
         p_ff   <= 18'd0;
      end
      if (state_ff == S_MARCH) begin
         zc_ff <= zq_ff[32:16];
         xq_ff <= xq_ff + dxs_ff;
         yq_ff <= yq_ff + dys_ff;
         zq_ff <= zq_ff + 40'(dzs_ff);
         if (p_ff <= ONE_Q16) begin
            p_ff <= p_ff + {1'b0, s_ff};
         end
      end
   end

endmodule

// File: sv/heightfield_line_of_sight_core.sv
// top level: register port, front end, queue and back end of the line-of-sight core
// depends on hlos_pkg, hlos_front, hlos_queue, hlos_back
//
// req channel takes one word per command: minimum or maximum height writes for a
// cell, or a line-of-sight query; command 3 is dropped without a result.
// rsp channel returns one visible bit per query, in query order.
// a write is taken straight from the queue. a query outside the grid or at or above
// the level count answers visible without a march. a marching query passes load
// and setup states, a bit-by-bit step root search (17 bits, each a square step,
// then a scale and compare step; skipped when source and target coincide), a
// scaling step and the sample march, which ends at the first blocked sample or
// once the target is passed. the sample loop is set by one min-map read per cycle.
// a two-word queue lets the front accept words while the back marches.
// reset clears the queue, the result register and the registers to their
// defaults; height maps hold garbage until written.
// while rsp is stalled the result register holds and the back end waits before
// posting the next result; map writes go on only while no march result waits.
module heightfield_line_of_sight_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic [7:0]  req_height_value,
   input  logic [7:0]  req_src_level,
   input  logic [5:0]  req_dst_x,
   input  logic [5:0]  req_dst_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_visible,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   hlos_pkg::cfg_type cfg_ff;
   hlos_pkg::op_type  push_op;
   hlos_pkg::op_type  head;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width    <= 7'd64;
         cfg_ff.grid_height   <= 7'd64;
         cfg_ff.level_count   <= 8'd1;
         cfg_ff.level_spacing <= 8'd1;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            hlos_pkg::REG_GRID_WIDTH:    cfg_ff.grid_width    <= csr_pwdata[6:0];
            hlos_pkg::REG_GRID_HEIGHT:   cfg_ff.grid_height   <= csr_pwdata[6:0];
            hlos_pkg::REG_LEVEL_COUNT:   cfg_ff.level_count   <= csr_pwdata[7:0];
            hlos_pkg::REG_LEVEL_SPACING: cfg_ff.level_spacing <= csr_pwdata[7:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         hlos_pkg::REG_GRID_WIDTH:    csr_prdata = {25'd0, cfg_ff.grid_width};
         hlos_pkg::REG_GRID_HEIGHT:   csr_prdata = {25'd0, cfg_ff.grid_height};
         hlos_pkg::REG_LEVEL_COUNT:   csr_prdata = {24'd0, cfg_ff.level_count};
         hlos_pkg::REG_LEVEL_SPACING: csr_prdata = {24'd0, cfg_ff.level_spacing};
         default: csr_prdata = 32'd0;
      endcase
   end

   hlos_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_height_value (req_height_value),
      .req_src_level    (req_src_level),
      .req_dst_x        (req_dst_x),
      .req_dst_y        (req_dst_y),
      .cfg              (cfg_ff),
      .q_full           (q_full),
      .push             (push),
      .push_op          (push_op)
   );

   hlos_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .full    (q_full),
      .empty   (q_empty),
      .head    (head)
   );

   hlos_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_visible (rsp_visible)
   );

endmodule

// File: dv/tb_top.sv
// self-checking testbench for heightfield_line_of_sight_core: preloads both height maps,
// then runs directed and random words over several register settings
// depends on hlos_pkg and the core rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE_Q16 = 65536;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int FILL_DIM = 16;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = hlos_pkg::CMD_WRITE_MIN;
   logic [5:0]  req_cell_x = '0;
   logic [5:0]  req_cell_y = '0;
   logic [7:0]  req_height_value = '0;
   logic [7:0]  req_src_level = '0;
   logic [5:0]  req_dst_x = '0;
   logic [5:0]  req_dst_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_visible;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int errors = 0;
   int cycles = 0;
   int stall_mode = 0;

   heightfield_line_of_sight_core u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   class los_scoreboard;
      logic [7:0] min_map[hlos_pkg::GRID_DIM*hlos_pkg::GRID_DIM];
      logic [7:0] max_map[hlos_pkg::GRID_DIM*hlos_pkg::GRID_DIM];
      hlos_pkg::cfg_type cfg;
      bit         visible_q[$];

      function new();
         cfg = '{grid_width: 7'd64, grid_height: 7'd64, level_count: 8'd1,
                 level_spacing: 8'd1};
      endfunction

      function longint step_of(longint d2);
         longint lo, hi, mid;
         lo = 0;
         hi = ONE_Q16;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * d2 <= 64'h1_0000_0000) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function bit sight(int sx, int sy, int lvl, int tx, int ty);
         int gw, gh, sp, x, y;
         longint dx, dy, sz, dz, d2, stp, p, xq, yq, zq;
         gw = cfg.grid_width > hlos_pkg::GRID_DIM ? hlos_pkg::GRID_DIM : cfg.grid_width;
         gh = cfg.grid_height > hlos_pkg::GRID_DIM ? hlos_pkg::GRID_DIM : cfg.grid_height;
         sp = cfg.level_spacing == 0 ? 1 : cfg.level_spacing;
         if (sx >= gw || sy >= gh || tx >= gw || ty >= gh || lvl >= cfg.level_count)
            return 1'b1;
         dx = tx - sx;
         dy = ty - sy;
         sz = sp - 1 + longint'(lvl) * sp;
         dz = longint'(max_map[ty*hlos_pkg::GRID_DIM+tx]) - sz;
         d2 = dx * dx + dy * dy;
         stp = d2 == 0 ? ONE_Q16 + 1 : step_of(d2);
         p = 0;
         while (p <= ONE_Q16) begin
            xq = sx * ONE_Q16 + dx * p;
            yq = sy * ONE_Q16 + dy * p;
            zq = sz * ONE_Q16 + dz * p;
            x = int'(xq >>> 16);
            y = int'(yq >>> 16);
            if (x >= hlos_pkg::GRID_DIM || y >= hlos_pkg::GRID_DIM) break;
            if ((zq >>> 16) < longint'(min_map[y*hlos_pkg::GRID_DIM+x])) return 1'b0;
            p += stp;
         end
         return 1'b1;
      endfunction

      function void note_word(logic [1:0] cmd, int cx, int cy, int hv, int lvl,
                              int tx, int ty);
         case (cmd)
            hlos_pkg::CMD_WRITE_MIN: min_map[cy*hlos_pkg::GRID_DIM+cx] = 8'(hv);
            hlos_pkg::CMD_WRITE_MAX: max_map[cy*hlos_pkg::GRID_DIM+cx] = 8'(hv);
            hlos_pkg::CMD_QUERY: visible_q.push_back(sight(cx, cy, lvl, tx, ty));
            default: ;
         endcase
      endfunction

      task check_word(logic vis);
         bit want;
         if (visible_q.size() == 0) begin
            report("result word with nothing expected");
            return;
         end
         want = visible_q.pop_front();
         if (vis !== want) report($sformatf("visible %b, expected %b", vis, want));
      endtask
   endclass

   los_scoreboard sb = new();

   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_visible);
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("heightfield_line_of_sight_core regression: fail");
         $finish;
      end
   end

   // receiver stall, with modes that never stall, stall lightly or stall in bursts
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 20);
         default: rsp_stall <= rsp_stall ? ($urandom_range(0, 99) < 90)
                                         : ($urandom_range(0, 99) < 5);
      endcase
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send(logic [1:0] cmd, int cx, int cy, int hv, int lvl, int tx, int ty,
                       int gap);
      @(negedge clock);
      req_valid = 1'b1;
      req_command = cmd;
      req_cell_x = 6'(cx);
      req_cell_y = 6'(cy);
      req_height_value = 8'(hv);
      req_src_level = 8'(lvl);
      req_dst_x = 6'(tx);
      req_dst_y = 6'(ty);
      do @(posedge clock); while (req_stall);
      sb.note_word(cmd, cx, cy, hv, lvl, tx, ty);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.visible_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (idx)
         hlos_pkg::REG_GRID_WIDTH: sb.cfg.grid_width = value[6:0];
         hlos_pkg::REG_GRID_HEIGHT: sb.cfg.grid_height = value[6:0];
         hlos_pkg::REG_LEVEL_COUNT: sb.cfg.level_count = value[7:0];
         default: sb.cfg.level_spacing = value[7:0];
      endcase
   endtask

   function automatic int pick_coord(int lim);
      int l;
      l = lim > hlos_pkg::GRID_DIM ? hlos_pkg::GRID_DIM : lim;
      if (l > 0 && $urandom_range(0, 99) < 90) return $urandom_range(0, l - 1);
      return $urandom_range(0, 63);
   endfunction

   task automatic random_words(int count);
      int r, lvl;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            lvl = (sb.cfg.level_count > 0 && $urandom_range(0, 99) < 85)
                  ? $urandom_range(0, sb.cfg.level_count - 1) : $urandom_range(0, 254);
            send(hlos_pkg::CMD_QUERY, pick_coord(sb.cfg.grid_width),
                 pick_coord(sb.cfg.grid_height), $urandom_range(0, 255), lvl,
                 pick_coord(sb.cfg.grid_width), pick_coord(sb.cfg.grid_height), gap_len());
         end else if (r < 95) begin
            send(r < 75 ? hlos_pkg::CMD_WRITE_MIN : hlos_pkg::CMD_WRITE_MAX,
                 $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 63),
                 gap_len());
         end else begin
            send(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 63),
                 $urandom_range(0, 63), gap_len());
         end
      end
   endtask

   task automatic set_cfg(int w, int h, int cnt, int sp);
      csr_write(hlos_pkg::REG_GRID_WIDTH, w);
      csr_write(hlos_pkg::REG_GRID_HEIGHT, h);
      csr_write(hlos_pkg::REG_LEVEL_COUNT, cnt);
      csr_write(hlos_pkg::REG_LEVEL_SPACING, sp);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill a corner block and the main diagonal so no query reads an unwritten cell
      stall_mode = 1;
      for (int y = 0; y < FILL_DIM; y++) begin
         for (int x = 0; x < FILL_DIM; x++) begin
            send(hlos_pkg::CMD_WRITE_MIN, x, y, $urandom_range(0, 120), 0, 0, 0,
                 $urandom_range(0, 99) < 95 ? 0 : 2);
            send(hlos_pkg::CMD_WRITE_MAX, x, y, $urandom_range(0, 255), 0, 0, 0, 0);
         end
      end
      for (int k = FILL_DIM; k < hlos_pkg::GRID_DIM; k++) begin
         send(hlos_pkg::CMD_WRITE_MIN, k, k, $urandom_range(0, 120), 0, 0, 0, 0);
         send(hlos_pkg::CMD_WRITE_MAX, k, k, $urandom_range(0, 255), 0, 0, 0, 0);
      end
      drain();

      // directed words
      set_cfg(64, 64, 255, 1);
      send(hlos_pkg::CMD_WRITE_MIN, 63, 63, 255, 0, 0, 0, 0);
      send(hlos_pkg::CMD_WRITE_MAX, 63, 63, 255, 0, 0, 0, 1);
      send(hlos_pkg::CMD_WRITE_MIN, 0, 0, 0, 0, 0, 0, 0);
      send(hlos_pkg::CMD_WRITE_MAX, 0, 0, 0, 0, 0, 0, 0);
      send(hlos_pkg::CMD_QUERY, 5, 7, 0, 0, 5, 7, 0);
      send(hlos_pkg::CMD_QUERY, 63, 63, 0, 0, 63, 63, 0);
      send(hlos_pkg::CMD_QUERY, 0, 0, 0, 0, 63, 63, 0);
      send(hlos_pkg::CMD_QUERY, 63, 63, 0, 254, 0, 0, 0);
      send(hlos_pkg::CMD_QUERY, 0, 15, 0, 3, 15, 0, 2);
      send(hlos_pkg::CMD_QUERY, 10, 10, 0, 0, 11, 10, 0);
      send(hlos_pkg::CMD_QUERY, 0, 0, 0, 128, 0, 15, 0);
      send(CMD_UNUSED, 1, 1, 255, 254, 63, 63, 0);
      send(hlos_pkg::CMD_WRITE_MIN, 32, 32, 255, 0, 0, 0, 0);
      send(hlos_pkg::CMD_QUERY, 30, 30, 0, 0, 34, 34, 0);
      drain();
      set_cfg(127, 127, 255, 1);
      send(hlos_pkg::CMD_QUERY, 63, 63, 0, 3, 62, 62, 0);
      send(hlos_pkg::CMD_QUERY, 40, 40, 0, 0, 20, 20, 0);
      drain();
      set_cfg(12, 15, 16, 3);
      send(hlos_pkg::CMD_QUERY, 11, 14, 0, 15, 0, 0, 0);
      send(hlos_pkg::CMD_QUERY, 12, 0, 0, 0, 0, 0, 0);
      send(hlos_pkg::CMD_QUERY, 0, 15, 0, 0, 0, 0, 0);
      send(hlos_pkg::CMD_QUERY, 0, 0, 0, 16, 1, 1, 0);
      send(hlos_pkg::CMD_WRITE_MIN, 63, 0, 200, 0, 0, 0, 0);
      send(hlos_pkg::CMD_WRITE_MAX, 0, 63, 100, 0, 0, 0, 0);
      drain();

      set_cfg(16, 16, 255, 1);
      stall_mode = 0;
      random_words(120);
      drain();

      set_cfg(16, 12, 40, 0);
      stall_mode = 2;
      random_words(120);
      drain();

      set_cfg(1, 1, 1, 255);
      stall_mode = 1;
      random_words(100);
      drain();

      set_cfg(0, 5, 0, 0);
      random_words(80);
      drain();

      set_cfg(16, 16, 4, 8);
      stall_mode = 2;
      random_words(120);
      drain();

      if (errors == 0) $display("heightfield_line_of_sight_core regression: pass");
      else $display("heightfield_line_of_sight_core regression: fail");
      $finish;
   end
endmodule

// File: files.f
sv/hlos_pkg.sv
sv/hlos_front.sv
sv/hlos_queue.sv
sv/hlos_back.sv
sv/heightfield_line_of_sight_core.sv
dv/tb_top.sv
